/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("duration parser assertion failed");

// Overlapping implication built on the macro above.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  `ASSERT_CLK(lbl, (ante) |-> (cons))

`endif

/* hw/rtl/dsp_pkg.sv */
// Types and constants of the duration string parser.
`timescale 1ns / 1ps

package dsp_pkg;

  // Largest total in seconds that a duration may reach.
  localparam logic [30:0] SecondsLimit = 31'h7FFF_FFFF;

  // Width of a unit weight; a day has 86400 seconds.
  localparam int unsigned WeightW = 17;

  typedef enum logic [2:0] {
    UNIT_NONE,
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR,
    UNIT_DAY
  } unit_e;

  typedef struct packed {
    logic [15:0] char_code;
    logic        char_valid;
    logic        is_last;
  } dsp_in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [30:0] seconds;
  } dsp_out_t;

  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    unit_e      unit;
  } dsp_class_t;

  function automatic logic [WeightW-1:0] unit_weight(unit_e unit);
    logic [WeightW-1:0] w;
    unique case (unit)
      UNIT_SEC:  w = 17'd1;
      UNIT_MIN:  w = 17'd60;
      UNIT_HOUR: w = 17'd3600;
      UNIT_DAY:  w = 17'd86400;
      default:   w = '0;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/dsp_char_class.sv */
// Character classifier: whitespace, decimal digit and unit letter.
`timescale 1ns / 1ps

module dsp_char_class (
  input  logic [15:0]         char_code_i,
  output dsp_pkg::dsp_class_t class_o
);

  logic space;

  always_comb begin
    space = ((char_code_i >= 16'h0009) && (char_code_i <= 16'h000D)) ||
            (char_code_i == 16'h0020) || (char_code_i == 16'h0085) ||
            (char_code_i == 16'h00A0) || (char_code_i == 16'h1680) ||
            ((char_code_i >= 16'h2000) && (char_code_i <= 16'h200A)) ||
            (char_code_i == 16'h2028) || (char_code_i == 16'h2029) ||
            (char_code_i == 16'h202F) || (char_code_i == 16'h205F) ||
            (char_code_i == 16'h3000);
  end

  always_comb begin
    class_o.is_space = space;
    class_o.is_digit = (char_code_i >= 16'h0030) && (char_code_i <= 16'h0039);
    class_o.digit    = char_code_i[3:0];
    unique case (char_code_i)
      16'h0073, 16'h0053: class_o.unit = dsp_pkg::UNIT_SEC;
      16'h006D, 16'h004D: class_o.unit = dsp_pkg::UNIT_MIN;
      16'h0068, 16'h0048: class_o.unit = dsp_pkg::UNIT_HOUR;
      16'h0064, 16'h0044: class_o.unit = dsp_pkg::UNIT_DAY;
      default:            class_o.unit = dsp_pkg::UNIT_NONE;
    endcase
  end

endmodule

/* hw/rtl/dsp_accum.sv */
// Parser state and the per-character update of number and total.
`timescale 1ns / 1ps

module dsp_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dsp_pkg::dsp_in_t   item_i,
  output dsp_pkg::dsp_out_t  result_o
);

  logic [30:0] number_q, number_d, number_upd;
  logic [30:0] total_q, total_d, total_upd;
  logic        digit_seen_q, digit_seen_d, digit_seen_upd;
  logic        unit_seen_q, unit_seen_d, unit_seen_upd;
  logic        failed_q, failed_d, failed_upd;

  dsp_pkg::dsp_class_t        cls;
  logic                       take;
  logic [34:0]                num_next;
  logic [dsp_pkg::WeightW-1:0] weight;
  logic [47:0]                prod;
  logic [48:0]                tsum;
  logic                       ok;

  dsp_char_class u_class (
    .char_code_i (item_i.char_code),
    .class_o     (cls)
  );

  always_comb begin
    // number * 10 + digit as two shifts and two adds.
    num_next = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0} +
               {31'd0, cls.digit};
    weight   = dsp_pkg::unit_weight(cls.unit);
    prod     = 48'(number_q) * 48'(weight);
    tsum     = 49'(prod) + 49'(total_q);
    take     = item_i.char_valid && !failed_q && !cls.is_space;
  end

  always_comb begin
    number_upd     = number_q;
    total_upd      = total_q;
    digit_seen_upd = digit_seen_q;
    unit_seen_upd  = unit_seen_q;
    failed_upd     = failed_q;
    if (take) begin
      priority if (cls.is_digit) begin
        digit_seen_upd = 1'b1;
        if (num_next > 35'(dsp_pkg::SecondsLimit)) begin
          failed_upd = 1'b1;
        end else begin
          number_upd = num_next[30:0];
        end
      end else if (!digit_seen_q) begin
        failed_upd = 1'b1;
      end else if (cls.unit == dsp_pkg::UNIT_NONE) begin
        failed_upd = 1'b1;
      end else if (tsum > 49'(dsp_pkg::SecondsLimit)) begin
        failed_upd = 1'b1;
      end else begin
        total_upd      = tsum[30:0];
        number_upd     = '0;
        digit_seen_upd = 1'b0;
        unit_seen_upd  = 1'b1;
      end
    end

    ok = !failed_upd && !digit_seen_upd && unit_seen_upd && (total_upd != '0);
    result_o.parse_ok = ok;
    result_o.seconds  = ok ? total_upd : '0;

    // The final item of a string returns the parser to its idle state.
    if (item_i.is_last) begin
      number_d     = '0;
      total_d      = '0;
      digit_seen_d = 1'b0;
      unit_seen_d  = 1'b0;
      failed_d     = 1'b0;
    end else begin
      number_d     = number_upd;
      total_d      = total_upd;
      digit_seen_d = digit_seen_upd;
      unit_seen_d  = unit_seen_upd;
      failed_d     = failed_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_q     <= '0;
      total_q      <= '0;
      digit_seen_q <= 1'b0;
      unit_seen_q  <= 1'b0;
      failed_q     <= 1'b0;
    end else if (step_i) begin
      number_q     <= number_d;
      total_q      <= total_d;
      digit_seen_q <= digit_seen_d;
      unit_seen_q  <= unit_seen_d;
      failed_q     <= failed_d;
    end
  end

endmodule

/* hw/rtl/duration_string_parser.sv */
// Top level of the duration string parser: input stage, parser and result register.
`timescale 1ns / 1ps
// Usage:
// A duration string such as "1h 30m" arrives on the input channel one
// character per request (in_valid_i, in_ready_o, in_data_i). The request
// marked is_last closes the string; an empty string is one request with
// char_valid low and is_last high. Requests without is_last give no result.
// For each closed string one result request leaves on the output channel
// (out_valid_o, out_ready_i, out_data_o) carrying parse_ok and the seconds.
// A last character accepted on the input is held in the input stage register,
// then moves through the parser stage, and its result is written to the
// result register, from which the receiver takes it on the output channel.
// Throughput: one character per cycle unless a string end stalls behind a
// pending result; the parser updates the number and total registers per character.
// While the result register holds an unread result, the stage behind it
// still takes characters that do not end a string; a second string end
// waits in the input stage until the receiver takes the pending result,
// and the input then stalls as well.
// Reset clears the valid flags of the input stage and the result register and
// all parser state, so the first character after reset starts a fresh string.
module duration_string_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsp_pkg::dsp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsp_pkg::dsp_out_t out_data_o
);

  // Input stage register.
  logic              stage_valid_q, stage_valid_d;
  dsp_pkg::dsp_in_t  stage_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  dsp_pkg::dsp_out_t out_q;

  dsp_pkg::dsp_out_t result;
  logic              advance;
  logic              in_fire;

  // The staged character moves on unless it ends a string while the result
  // register is still occupied by a result nobody has taken.
  assign advance    = stage_valid_q && (!stage_q.is_last || !out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  dsp_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (stage_q),
    .result_o (result)
  );

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_fire) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && stage_q.is_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q <= in_data_i;
    end
    if (advance && stage_q.is_last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/dsp_checker.sv */
// Port-level checker of the duration string parser and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dsp_pkg::dsp_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dsp_pkg::dsp_out_t out_data_o
);

  // A result that is not taken stays put.
  `ASSERT_CLK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))

  // A failed parse reports zero seconds.
  `ASSERT_IMPLIES(a_fail_zero, out_valid_o && !out_data_o.parse_ok, out_data_o.seconds == '0)

  // A good parse always reports a positive duration.
  `ASSERT_IMPLIES(a_ok_positive, out_valid_o && out_data_o.parse_ok, out_data_o.seconds != '0)

  // A new result appears only after a string end was taken on the input.
  `ASSERT_IMPLIES(a_result_cause, $rose(out_valid_o), $past(in_valid_i && in_ready_o && in_data_i.is_last, 2))

endmodule

bind duration_string_parser dsp_checker u_dsp_checker (.*);
